// ===== src/fpdc_pkg.sv =====
package fpdc_pkg;

  localparam int unsigned SigWidth = 53;
  localparam int unsigned ExpWidth = 12;

  // fraction bits and exponent offsets per format
  localparam logic signed [ExpWidth-1:0] BiasDbl     = 12'sd1023;
  localparam logic signed [ExpWidth-1:0] BiasSgl     = 12'sd127;
  localparam logic signed [ExpWidth-1:0] NormOffsDbl = 12'sd1075;  // bias + fraction bits
  localparam logic signed [ExpWidth-1:0] NormOffsSgl = 12'sd150;
  localparam logic signed [ExpWidth-1:0] SubExpDbl   = -12'sd1074; // 1 - bias - fraction bits
  localparam logic signed [ExpWidth-1:0] SubExpSgl   = -12'sd149;

  localparam int unsigned ShiftWidth = 6;

  typedef enum logic [2:0] {
    CLS_NORMAL    = 3'd0,
    CLS_ZERO      = 3'd1,
    CLS_SUBNORMAL = 3'd2,
    CLS_INF       = 3'd3,
    CLS_NAN       = 3'd4
  } value_class_e;

  typedef struct packed {
    logic                       sign;
    value_class_e               value_class;
    logic [SigWidth-1:0]        significand;
    logic signed [ExpWidth-1:0] binary_exponent;
    logic                       strip;  // finite nonzero: trailing zeros to be removed
  } unpacked_t;

endpackage

// ===== src/fpdc_classify.sv =====
module fpdc_classify
  import fpdc_pkg::*;
(
  input  logic        op_i,
  input  logic [63:0] raw_bits_i,
  output unpacked_t   unp_o
);

  logic        sign;
  logic [10:0] efield;
  logic [51:0] frac;
  logic        exp_max;
  logic        exp_zero;
  logic        frac_zero;
  logic signed [ExpWidth-1:0] efield_s;

  always_comb begin
    if (op_i) begin
      sign    = raw_bits_i[63];
      efield  = raw_bits_i[62:52];
      frac    = raw_bits_i[51:0];
      exp_max = &raw_bits_i[62:52];
    end else begin
      sign    = raw_bits_i[31];
      efield  = {3'b000, raw_bits_i[30:23]};
      frac    = {29'd0, raw_bits_i[22:0]};
      exp_max = &raw_bits_i[30:23];
    end
  end

  assign exp_zero  = (efield == 11'd0);
  assign frac_zero = (frac == 52'd0);
  assign efield_s  = $signed({1'b0, efield});

  always_comb begin
    unp_o.sign = sign;
    unp_o.strip = 1'b0;
    if (exp_zero && frac_zero) begin
      unp_o.value_class     = CLS_ZERO;
      unp_o.significand     = '0;
      unp_o.binary_exponent = op_i ? -BiasDbl : -BiasSgl;
    end else if (exp_max) begin
      unp_o.value_class     = frac_zero ? CLS_INF : CLS_NAN;
      unp_o.significand     = {1'b0, frac};
      unp_o.binary_exponent = efield_s - (op_i ? BiasDbl : BiasSgl);
    end else if (exp_zero) begin
      unp_o.value_class     = CLS_SUBNORMAL;
      unp_o.significand     = {1'b0, frac};
      unp_o.binary_exponent = op_i ? SubExpDbl : SubExpSgl;
      unp_o.strip           = 1'b1;
    end else begin
      unp_o.value_class = CLS_NORMAL;
      // hidden bit sits just above the fraction field
      unp_o.significand = op_i ? {1'b1, frac} : {29'd0, 1'b1, frac[22:0]};
      unp_o.binary_exponent = efield_s - (op_i ? NormOffsDbl : NormOffsSgl);
      unp_o.strip           = 1'b1;
    end
  end

endmodule

// ===== src/fpdc_strip.sv =====
module fpdc_strip
  import fpdc_pkg::*;
(
  input  unpacked_t                  unp_i,
  output logic [SigWidth-1:0]        significand_o,
  output logic signed [ExpWidth-1:0] binary_exponent_o
);

  logic [SigWidth-1:0]   sig;
  logic [ShiftWidth-1:0] cnt;

  // binary search for trailing zeros, widest step first; input is nonzero when strip is set
  always_comb begin
    sig = unp_i.significand;
    cnt = '0;
    if (unp_i.strip) begin
      for (int k = ShiftWidth - 1; k >= 0; k--) begin
        if ((sig & ~({SigWidth{1'b1}} << (1 << k))) == '0) begin
          sig = sig >> (1 << k);
          cnt = cnt | ShiftWidth'(1 << k);
        end
      end
    end
  end

  assign significand_o     = sig;
  assign binary_exponent_o = unp_i.binary_exponent
                           + $signed({{(ExpWidth - ShiftWidth){1'b0}}, cnt});

endmodule

// ===== src/ieee754_decompose_classify_core.sv =====
// IEEE 754 binary32/binary64 unpack and classify. Each transfer on the slave side carries a raw
// bit pattern (tdata) and a format select in tuser (0 single precision in the low 32 bits,
// 1 double precision); each produces exactly one result transfer with the sign, the class
// (normal, zero, subnormal, infinity, NaN), an odd significand and a signed exponent so that
// value = (-1)^sign * significand * 2^exponent. For zero, infinity and NaN the raw fraction
// and the unbiased raw exponent are returned. One item per clock is sustained while the
// downstream side accepts. The input register is followed by the result register, with the
// classify and trailing-zero strip logic between them. While a result waits downstream, an
// empty input register still takes an item; input stalls once both registers hold an item.
module ieee754_decompose_classify_core
  import fpdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // raw_bits
  input  logic        s_axis_tuser_i,  // op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,  // sign, significand, binary_exponent, zero fill
  output logic [2:0]  m_axis_tuser_o   // value_class
);

  logic        in_valid_q;
  logic        op_q;
  logic [63:0] raw_q;
  logic        out_valid_q;
  logic        sign_q;
  logic [2:0]  cls_q;
  logic [SigWidth-1:0]        sig_q;
  logic signed [ExpWidth-1:0] exp_q;

  logic        out_ready;
  logic        in_ready;
  unpacked_t   unp;
  logic [SigWidth-1:0]        sig_d;
  logic signed [ExpWidth-1:0] exp_d;

  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign in_ready        = !in_valid_q || out_ready;
  assign s_axis_tready_o = in_ready;

  fpdc_classify u_classify (
    .op_i       (op_q),
    .raw_bits_i (raw_q),
    .unp_o      (unp)
  );

  fpdc_strip u_strip (
    .unp_i             (unp),
    .significand_o     (sig_d),
    .binary_exponent_o (exp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid_i) begin
      op_q  <= s_axis_tuser_i;
      raw_q <= s_axis_tdata_i;
    end
    if (out_ready && in_valid_q) begin
      sign_q <= unp.sign;
      cls_q  <= unp.value_class;
      sig_q  <= sig_d;
      exp_q  <= exp_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = cls_q;
  assign m_axis_tdata_o  = {6'd0, exp_q, sig_q, sign_q};

endmodule
